FILE: rtl/text_console_char_writer_unit_macros.svh
// Assertion macros shared by the console checker.
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define TCW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// Next-cycle implication, off while reset is held.
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

// Next-cycle implication that also runs through reset.
`define TCW_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

FILE: rtl/tcw_pkg.sv
// Shared constants, command codes and types of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELLS          = COLUMNS * ROWS;
  localparam int LAST_ROW_START = CELLS - COLUMNS;
  localparam int ADDR_W         = $clog2(CELLS);
  localparam int COL_W          = $clog2(COLUMNS);

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT        = 2'd0,
    CMD_CLEAR      = 2'd1,
    CMD_CLEAR_HOME = 2'd2,
    CMD_READ       = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    OP_PUT        = 3'd0,
    OP_NEWLINE    = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_CLEAR_HOME = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  // Classified word handed from front to back.
  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] idx;
    logic              idx_ok;
  } cmd_word_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

`default_nettype wire

FILE: rtl/tcw_ifs.sv
// Valid/ready channel interfaces: command input, result output, attribute write.
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0] cell_index;

  modport source (output valid, output command, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input command, input char_code, input cell_index,
                output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;
  logic              scrolled;

  modport source (output valid, output cursor_position, output cell_char,
                  output cell_attr, output scrolled, input ready);
  modport sink (input valid, input cursor_position, input cell_char,
                input cell_attr, input scrolled, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] text_attribute;

  modport source (output valid, output text_attribute, input ready);
  modport sink (input valid, input text_attribute, output ready);
endinterface

`default_nettype wire

FILE: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/tcw_queue.sv
// Short FIFO of classified words between the front and back ends.
`default_nettype none

module tcw_queue import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_word_t push_word,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output cmd_word_t pop_word
);

  cmd_word_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_word = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_front.sv
// Front end: takes command words, classifies them and feeds the queue.
`default_nettype none

module tcw_front import tcw_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  tcw_in_if.sink       in_if,
  input  back_status_t status,
  input  logic         q_full,
  output logic         push,
  output cmd_word_t    push_word
);

  logic              front_valid_r, front_valid_nxt;
  cmd_word_t         front_word_r;
  cmd_word_t         word_cls;
  logic [CMP_W-1:0]  idx_ext;
  logic              accept;

  assign push         = front_valid_r && !q_full;
  assign push_word    = front_word_r;
  assign in_if.ready  = !status.init_busy && (!front_valid_r || push);
  assign accept       = in_if.valid && in_if.ready;

  always_comb begin
    idx_ext         = CMP_W'(in_if.cell_index);
    word_cls.ch     = in_if.char_code;
    word_cls.idx    = idx_ext[ADDR_W-1:0];
    word_cls.idx_ok = (idx_ext < CMP_W'(CELLS));
    unique case (cmd_code_t'(in_if.command))
      CMD_PUT: begin
        word_cls.op = (in_if.char_code == CH_LF || in_if.char_code == CH_CR) ?
                      OP_NEWLINE : OP_PUT;
      end
      CMD_CLEAR:      word_cls.op = OP_CLEAR;
      CMD_CLEAR_HOME: word_cls.op = OP_CLEAR_HOME;
      CMD_READ:       word_cls.op = OP_READ;
    endcase
  end

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (push) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_word_r <= word_cls;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_back.sv
// Back end: cursor, cell stores, scroll and clear walks, result register.
`default_nettype none

module tcw_back import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  cmd_word_t         q_word,
  output logic              q_pop,
  input  logic [ATTR_W-1:0] text_attr,
  output back_status_t      status,
  tcw_out_if.source         out_if
);

  typedef enum logic [3:0] {
    ST_FILL  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_READ  = 4'b0100,
    ST_BLANK = 4'b1000
  } back_state_t;

  // Character rows are a ring: base_off_r is where logical row 0 sits.
  function automatic logic [ADDR_W-1:0] to_phys(input logic [ADDR_W-1:0] lin,
                                                input logic [ADDR_W-1:0] base);
    logic [ADDR_W:0] sum;
    sum = {1'b0, lin} + {1'b0, base};
    if (sum >= (ADDR_W+1)'(CELLS)) begin
      sum = sum - (ADDR_W+1)'(CELLS);
    end
    return sum[ADDR_W-1:0];
  endfunction

  back_state_t       state_r, state_nxt;
  logic              init_r, init_nxt;
  logic [ADDR_W-1:0] walk_r, walk_nxt;
  logic [ADDR_W-1:0] blank_addr_r, blank_addr_nxt;
  logic [ADDR_W-1:0] base_off_r, base_off_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ADDR_W-1:0] row_start_r, row_start_nxt;
  logic [ADDR_W-1:0] cur_lin_r, cur_lin_nxt;
  logic [ATTR_W-1:0] fill_attr_r, fill_attr_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [ATTR_W-1:0] out_attr_r, out_attr_nxt;
  logic              out_scr_r, out_scr_nxt;
  logic              out_load;
  logic              out_free;

  logic              char_we, attr_we;
  logic [ADDR_W-1:0] char_waddr, attr_waddr;
  logic [CHAR_W-1:0] char_wdata, char_rdata;
  logic [ATTR_W-1:0] attr_wdata, attr_rdata;
  logic [ADDR_W-1:0] char_raddr, attr_raddr;

  logic              last_row, last_col, scroll;
  logic [ADDR_W-1:0] base_adv;

  tcw_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (char_waddr),
    .wdata (char_wdata),
    .raddr (char_raddr),
    .rdata (char_rdata)
  );

  tcw_ram #(.WIDTH(ATTR_W), .DEPTH(CELLS)) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (attr_waddr),
    .wdata (attr_wdata),
    .raddr (attr_raddr),
    .rdata (attr_rdata)
  );

  assign out_free         = !out_valid_r || out_if.ready;
  assign q_pop            = (state_r == ST_RUN) && q_valid && out_free;
  assign status.init_busy = init_r;

  assign char_raddr = to_phys(q_word.idx, base_off_r);
  assign attr_raddr = q_word.idx;

  assign last_row = (row_start_r == ADDR_W'(LAST_ROW_START));
  assign last_col = (cur_col_r == COL_W'(COLUMNS - 1));
  assign base_adv = (base_off_r == ADDR_W'(LAST_ROW_START)) ? '0 :
                    base_off_r + ADDR_W'(COLUMNS);

  assign out_if.valid           = out_valid_r;
  assign out_if.cursor_position = out_pos_r;
  assign out_if.cell_char       = out_char_r;
  assign out_if.cell_attr       = out_attr_r;
  assign out_if.scrolled        = out_scr_r;

  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    walk_nxt       = walk_r;
    blank_addr_nxt = blank_addr_r;
    base_off_nxt   = base_off_r;
    cur_col_nxt    = cur_col_r;
    row_start_nxt  = row_start_r;
    cur_lin_nxt    = cur_lin_r;
    fill_attr_nxt  = fill_attr_r;
    rd_ok_nxt      = rd_ok_r;
    char_we        = 1'b0;
    char_waddr     = walk_r;
    char_wdata     = SPACE_CHAR;
    attr_we        = 1'b0;
    attr_waddr     = walk_r;
    attr_wdata     = fill_attr_r;
    scroll         = 1'b0;
    out_load       = 1'b0;
    out_char_nxt   = '0;
    out_attr_nxt   = '0;

    unique case (state_r)
      ST_FILL: begin
        char_we = 1'b1;
        attr_we = 1'b1;
        if (walk_r == ADDR_W'(CELLS - 1)) begin
          walk_nxt  = '0;
          init_nxt  = 1'b0;
          state_nxt = ST_RUN;
        end else begin
          walk_nxt = walk_r + 1'b1;
        end
      end
      ST_BLANK: begin
        char_we        = 1'b1;
        char_waddr     = blank_addr_r;
        blank_addr_nxt = blank_addr_r + 1'b1;
        if (walk_r == ADDR_W'(COLUMNS - 1)) begin
          walk_nxt  = '0;
          state_nxt = ST_RUN;
        end else begin
          walk_nxt = walk_r + 1'b1;
        end
      end
      ST_READ: begin
        out_load     = 1'b1;
        out_char_nxt = rd_ok_r ? char_rdata : '0;
        out_attr_nxt = rd_ok_r ? attr_rdata : '0;
        state_nxt    = ST_RUN;
      end
      ST_RUN: begin
        if (q_pop) begin
          unique case (q_word.op)
            OP_PUT: begin
              out_load   = 1'b1;
              char_we    = 1'b1;
              char_waddr = to_phys(cur_lin_r, base_off_r);
              char_wdata = q_word.ch;
              attr_we    = 1'b1;
              attr_waddr = cur_lin_r;
              attr_wdata = text_attr;
              if (last_col) begin
                cur_col_nxt = '0;
                if (last_row) begin
                  scroll      = 1'b1;
                  cur_lin_nxt = row_start_r;
                end else begin
                  row_start_nxt = row_start_r + ADDR_W'(COLUMNS);
                  cur_lin_nxt   = cur_lin_r + 1'b1;
                end
              end else begin
                cur_col_nxt = cur_col_r + 1'b1;
                cur_lin_nxt = cur_lin_r + 1'b1;
              end
            end
            OP_NEWLINE: begin
              out_load    = 1'b1;
              cur_col_nxt = '0;
              if (last_row) begin
                scroll      = 1'b1;
                cur_lin_nxt = row_start_r;
              end else begin
                row_start_nxt = row_start_r + ADDR_W'(COLUMNS);
                cur_lin_nxt   = row_start_r + ADDR_W'(COLUMNS);
              end
            end
            OP_CLEAR: begin
              out_load      = 1'b1;
              fill_attr_nxt = text_attr;
              state_nxt     = ST_FILL;
            end
            OP_CLEAR_HOME: begin
              out_load      = 1'b1;
              fill_attr_nxt = text_attr;
              cur_col_nxt   = '0;
              row_start_nxt = '0;
              cur_lin_nxt   = '0;
              state_nxt     = ST_FILL;
            end
            OP_READ: begin
              rd_ok_nxt = q_word.idx_ok;
              state_nxt = ST_READ;
            end
            default: begin
              state_nxt = ST_RUN;
            end
          endcase
          // Scroll: old top row becomes the new bottom row, blanked next.
          if (scroll) begin
            blank_addr_nxt = base_off_r;
            base_off_nxt   = base_adv;
            state_nxt      = ST_BLANK;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase

    out_pos_nxt   = POS_W'(cur_lin_nxt);
    out_scr_nxt   = scroll;
    out_valid_nxt = out_load ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      init_r      <= 1'b1;
      walk_r      <= '0;
      base_off_r  <= '0;
      cur_col_r   <= '0;
      row_start_r <= '0;
      cur_lin_r   <= '0;
      fill_attr_r <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      walk_r      <= walk_nxt;
      base_off_r  <= base_off_nxt;
      cur_col_r   <= cur_col_nxt;
      row_start_r <= row_start_nxt;
      cur_lin_r   <= cur_lin_nxt;
      fill_attr_r <= fill_attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blank_addr_r <= blank_addr_nxt;
    rd_ok_r      <= rd_ok_nxt;
    if (out_load) begin
      out_pos_r  <= out_pos_nxt;
      out_char_r <= out_char_nxt;
      out_attr_r <= out_attr_nxt;
      out_scr_r  <= out_scr_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/text_console_char_writer_unit.sv
// Text console writer top level: 80x25 character/attribute cells behind valid/ready channels.
// in_if carries one command word (put, clear, clear and home, read); out_if returns one
// result word per command; cfg_if writes the text attribute, always ready.
// A put or newline result passes the front register, the queue and the output register
// before it shows on out_if; a read result also holds the execution stage in ST_READ for
// the registered RAM read. Puts and newlines run one word per cycle end to end while out_if
// is ready and no scroll or clear is under way. On a scroll the row ring moves by one row and
// the freed row is blanked one cell per cycle through the character RAM write port.
// A clear sweeps both RAMs one cell per cycle.
// Words keep arriving into the front register and the two-entry queue meanwhile.
// After reset both RAMs are swept to spaces / attribute 0x07 with in_if.ready low;
// cursor and attribute return to home and 0x07.
// When out_if stalls, the result waits in the output register, the queue fills
// behind it and in_if.ready drops once the queue and front register are full.
`default_nettype none

module text_console_char_writer_unit import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tcw_in_if.sink     in_if,
  tcw_out_if.source  out_if,
  tcw_cfg_if.sink    cfg_if
);

  logic [ATTR_W-1:0] attr_r;
  back_status_t      status;
  logic              q_push, q_full, q_pop, q_valid;
  cmd_word_t         q_push_word, q_pop_word;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_if.valid) begin
      attr_r <= cfg_if.text_attribute;
    end
  end

  tcw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .status    (status),
    .q_full    (q_full),
    .push      (q_push),
    .push_word (q_push_word)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_push_word),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_word  (q_pop_word)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_pop_word),
    .q_pop     (q_pop),
    .text_attr (attr_r),
    .status    (status),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire

FILE: rtl/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
`default_nettype none

`include "text_console_char_writer_unit_macros.svh"

module tcw_checker import tcw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [POS_W-1:0]  out_cursor_position,
  input logic [CHAR_W-1:0] out_cell_char,
  input logic [ATTR_W-1:0] out_cell_attr,
  input logic              out_scrolled
);

  // store clearing pass keeps the input closed right after reset
  `TCW_ASSERT_NEXT_ALWAYS(a_closed_after_reset, !rst_n, !in_ready)

  `TCW_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid)

  `TCW_ASSERT_NEXT(a_out_word_holds, out_valid && !out_ready, $stable(out_cursor_position) && $stable(out_cell_char) && $stable(out_cell_attr) && $stable(out_scrolled))

  // only reads carry cell data, and reads never scroll
  `TCW_ASSERT_SAME(a_scroll_no_data, out_valid && out_scrolled, out_cell_char == '0 && out_cell_attr == '0)

endmodule

bind text_console_char_writer_unit tcw_checker u_tcw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_if.ready),
  .out_valid           (out_if.valid),
  .out_ready           (out_if.ready),
  .out_cursor_position (out_if.cursor_position),
  .out_cell_char       (out_if.cell_char),
  .out_cell_attr       (out_if.cell_attr),
  .out_scrolled        (out_if.scrolled)
);

`default_nettype wire
